### design/fmbq_pkg.sv
// Shared types and constants for the front/middle/back queue.
package fmbq_pkg;

	// Default geometry
	localparam int DefCapacity  = 64;
	localparam int DefDataWidth = 32;

	// Fixed field widths of the channels
	localparam int CmdW   = 3;
	localparam int ValueW = 32;
	localparam int OccW   = 7;

	typedef enum logic [CmdW-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_MID   = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_MID    = 3'd4,
		CMD_POP_BACK   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What every cell of the row does: hold, insert or remove
	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_INS  = 2'd1,
		SH_REM  = 2'd2
	} shift_op_t;

	typedef struct packed {
		shift_op_t op;
		status_t   status;
	} ctl_t;

endpackage

### design/fmbq_if.sv
// Command and result channel interfaces for the front/middle/back queue.
interface fmbq_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [fmbq_pkg::CmdW-1:0]             command;
	logic signed [fmbq_pkg::ValueW-1:0]    push_value;

	modport source (output valid, output command, output push_value, input ready);
	modport sink (input valid, input command, input push_value, output ready);
endinterface

interface fmbq_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [fmbq_pkg::ValueW-1:0]    pop_value;
	logic [1:0]                            status;
	logic [fmbq_pkg::OccW-1:0]             occupancy;

	modport source (output valid, output pop_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input pop_value, input status, input occupancy,
		output ready);
endinterface

### design/fmbq_cell.sv
// One storage cell of the queue row: holds one entry and shifts with its neighbours.
module fmbq_cell #(
	parameter int DATA_WIDTH = fmbq_pkg::DefDataWidth,
	parameter int POS_W      = 6,
	parameter int IDX        = 0
) (
	input  logic                    clk,
	input  fmbq_pkg::shift_op_t     op,
	input  logic [POS_W-1:0]        pos,
	input  logic [DATA_WIDTH-1:0]   left_data,
	input  logic [DATA_WIDTH-1:0]   right_data,
	input  logic [DATA_WIDTH-1:0]   ins_data,
	output logic [DATA_WIDTH-1:0]   data,
	output logic [DATA_WIDTH-1:0]   rd_part
);
	import fmbq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_pos;
	logic                  behind_pos;

	assign at_pos     = (POS_W'(IDX) == pos);
	assign behind_pos = (POS_W'(IDX) > pos);

	// Shift towards the back on insert, towards the front on remove
	always_ff @(posedge clk) begin
		case (op)
			SH_INS: begin
				if (behind_pos) begin
					data_q <= left_data;
				end else if (at_pos) begin
					data_q <= ins_data;
				end
			end
			SH_REM: begin
				if (behind_pos || at_pos) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data    = data_q;
	// Drive the shared read bus only when addressed
	assign rd_part = data_q & {DATA_WIDTH{at_pos}};

endmodule

### design/fmbq_ctrl.sv
// Command decode and entry count for the queue row.
module fmbq_ctrl #(
	parameter int CAPACITY = fmbq_pkg::DefCapacity,
	parameter int POS_W    = $clog2(CAPACITY),
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [fmbq_pkg::CmdW-1:0]   command,
	output fmbq_pkg::ctl_t              ctl,
	output logic [POS_W-1:0]            pos,
	output logic [CNT_W-1:0]            count_next
);
	import fmbq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_dec;
	logic [CNT_W-1:0] pos_wide;
	logic             full;
	logic             empty;
	cmd_t             cmd;
	ctl_t             ctl_raw;

	assign cmd       = cmd_t'(command);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign count_dec = count_q - 1'b1;

	// Decode the command into a row operation and a status
	always_comb begin
		ctl_raw.op     = SH_HOLD;
		ctl_raw.status = ST_DONE;
		unique case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_MID, CMD_PUSH_BACK: begin
				if (full) begin
					ctl_raw.status = ST_FULL;
				end else begin
					ctl_raw.op = SH_INS;
				end
			end
			CMD_POP_FRONT, CMD_POP_MID, CMD_POP_BACK: begin
				if (empty) begin
					ctl_raw.status = ST_EMPTY;
				end else begin
					ctl_raw.op = SH_REM;
				end
			end
			default: begin
				ctl_raw.op     = SH_HOLD;
				ctl_raw.status = ST_DONE;
			end
		endcase
	end

	// Select the affected position
	always_comb begin
		case (cmd)
			CMD_PUSH_MID:  pos_wide = count_q >> 1;
			CMD_PUSH_BACK: pos_wide = count_q;
			CMD_POP_MID:   pos_wide = count_dec >> 1;
			CMD_POP_BACK:  pos_wide = count_dec;
			default:       pos_wide = '0;
		endcase
	end

	assign pos = pos_wide[POS_W-1:0];

	// Gate the row operation with the handshake
	always_comb begin
		ctl = ctl_raw;
		if (!fire) begin
			ctl.op = SH_HOLD;
		end
	end

	always_comb begin
		case (ctl_raw.op)
			SH_INS:  count_next = count_q + 1'b1;
			SH_REM:  count_next = count_dec;
			default: count_next = count_q;
		endcase
	end

	// Advance the entry count on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl.status == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("push dropped while space remains");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl.op == SH_INS) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("insert did not grow the count");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl.op == SH_REM) |=> (count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("remove did not shrink the count");

endmodule

### design/front_middle_back_queue_core.sv
// Top level of the front/middle/back queue: cell row, control and result register.
//
// Usage:
//   cmd carries one command per transaction (push or pop at the front, the
//   middle or the back, with push_value for pushes). res returns exactly one
//   transaction per command: the popped value (-1 on an empty queue, zero for
//   pushes), a status (done, empty, full) and the occupancy after the command.
//   The result is valid in the cycle after command acceptance. One command
//   is taken per cycle while results are taken: every cell of the row shifts,
//   loads or holds in the same cycle, and the popped entry is picked off the
//   row's read bus. The result register decouples the sides: a new command is
//   taken while a result is pending provided that result is taken in the same
//   cycle; when the receiver stalls, the result holds and cmd.ready drops.
//   Reset empties the queue (count to zero) and clears the result valid; the
//   cell contents are not cleared, as only written entries are ever read.
//   Occupancy reports the low seven bits of the entry count.
module front_middle_back_queue_core #(
	parameter int CAPACITY   = fmbq_pkg::DefCapacity,
	parameter int DATA_WIDTH = fmbq_pkg::DefDataWidth
) (
	input  logic            clk,
	input  logic            arst_n,
	fmbq_cmd_if.sink        cmd,
	fmbq_res_if.source      res
);
	import fmbq_pkg::*;

	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                    fire;
	ctl_t                    ctl;
	logic [POS_W-1:0]        pos;
	logic [CNT_W-1:0]        count_next;
	logic [DATA_WIDTH-1:0]   ins_data;
	logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0]   rd_part   [CAPACITY];
	logic [DATA_WIDTH-1:0]   rd_data;
	logic [ValueW-1:0]       pop_value_d;

	logic                    res_valid_q;
	logic [ValueW-1:0]       pop_value_q;
	status_t                 status_q;
	logic [OccW-1:0]         occupancy_q;

	assign cmd.ready = !res_valid_q || res.ready;
	assign fire      = cmd.valid && cmd.ready;
	assign ins_data  = DATA_WIDTH'($unsigned(cmd.push_value));

	fmbq_ctrl #(
		.CAPACITY (CAPACITY),
		.POS_W    (POS_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.command    (cmd.command),
		.ctl        (ctl),
		.pos        (pos),
		.count_next (count_next)
	);

	// Build the row of cells, each linked to its neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = ins_data;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		fmbq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.POS_W      (POS_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.op         (ctl.op),
			.pos        (pos),
			.left_data  (left_d),
			.right_data (right_d),
			.ins_data   (ins_data),
			.data       (cell_data[i]),
			.rd_part    (rd_part[i])
		);
	end

	// Collect the addressed entry from the read bus
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | rd_part[i];
		end
	end

	// Form the popped value, sign-extended from the entry width
	always_comb begin
		if (ctl.status == ST_EMPTY) begin
			pop_value_d = '1;
		end else if (ctl.op == SH_REM) begin
			pop_value_d = ValueW'($signed(rd_data));
		end else begin
			pop_value_d = '0;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pop_value_q <= pop_value_d;
			status_q    <= ctl.status;
			occupancy_q <= OccW'(count_next);
		end
	end

	assign res.valid     = res_valid_q;
	assign res.pop_value = pop_value_q;
	assign res.status    = status_q;
	assign res.occupancy = occupancy_q;

endmodule
